FILE: hdl/clo_pkg.sv
// shared constants, codes and types for the circular log byte store
// no dependencies; used by every module of the block but clo_ram
package clo_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int RLEN_W      = ADDR_W + 1;
  localparam int DATA_W      = 8;
  localparam int TGT_W       = RLEN_W + 2;

  localparam logic [DATA_W-1:0] ERASED = 8'hFF;

  // request function codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_ERASE  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_NODATA  = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_CLEARED = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_RLEN  = 2'd2;

  localparam logic [ADDR_W-1:0] START_RST = '0;
  localparam logic [ADDR_W-1:0] END_RST   = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [RLEN_W-1:0] RLEN_RST  = RLEN_W'(64);

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [RLEN_W-1:0] record_length;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hdl/circular_log_byte_store_top.sv
// top level of the circular log byte store
// depends on clo_pkg, clo_ram, clo_regs and clo_seq
//
// usage:
//   in_*  : one request per handshake; in_tuser = func (append, read, erase),
//           in_tdata = wr_data and offset
//   out_* : one result per request; out_tuser = status, out_tdata = read_data
//   cfg_* : apb-style register port; start address at 0x0, end address at
//           0x4, record length at 0x8; write only while no request is open
// timing:
//   a request is taken only while the sequencer is idle; the store is one
//   1024 x 8 ram with registered read, and scans test one byte per cycle
//   append: scans from the pointer for an erased byte and writes it there;
//           when the log is full the whole store is wiped instead
//   read:   scans from start for an erased byte, then reads back a byte
//   erase:  wipes the whole store, one byte written per cycle
// reset:
//   rst_n clears the registers to their defaults and starts a clearing
//   pass over the whole ram; in_tready stays low until it ends
// stall:
//   a result waits in the output register while out_tready is low; the next
//   request may be taken and worked on, holding its result until the slot frees
module circular_log_byte_store_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] wr_data, [17:8] offset, [23:18] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  clo_pkg::cfg_t                    cfg;
  clo_pkg::mem_req_t                mem_req;
  logic [clo_pkg::DATA_W-1:0]       mem_rdata;

  // register block; writes always complete in the access cycle
  assign cfg_pready = 1'b1;

  clo_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // sequencer owns the log pointer and the result register
  clo_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser),
    .in_wr_data    (in_tdata[7:0]),
    .in_offset     (in_tdata[17:8]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (out_tuser),
    .out_read_data (out_tdata),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // byte store
  clo_ram #(
    .DEPTH (clo_pkg::STORE_DEPTH),
    .WIDTH (clo_pkg::DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: hdl/clo_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module clo_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/clo_regs.sv
// apb-style configuration registers: start address, end address, record length
// depends on clo_pkg
module clo_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output clo_pkg::cfg_t    cfg
);

  logic [clo_pkg::ADDR_W-1:0] start_r, start_nxt;
  logic [clo_pkg::ADDR_W-1:0] end_r, end_nxt;
  logic [clo_pkg::RLEN_W-1:0] rlen_r, rlen_nxt;
  logic                       wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    rlen_nxt  = rlen_r;
    if (wr_en) begin
      case (paddr[3:2])
        clo_pkg::REG_START: start_nxt = pwdata[clo_pkg::ADDR_W-1:0];
        clo_pkg::REG_END:   end_nxt   = pwdata[clo_pkg::ADDR_W-1:0];
        clo_pkg::REG_RLEN:  rlen_nxt  = pwdata[clo_pkg::RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= clo_pkg::START_RST;
      end_r   <= clo_pkg::END_RST;
      rlen_r  <= clo_pkg::RLEN_RST;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      rlen_r  <= rlen_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      clo_pkg::REG_START: prdata = 32'(start_r);
      clo_pkg::REG_END:   prdata = 32'(end_r);
      clo_pkg::REG_RLEN:  prdata = 32'(rlen_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.start_addr    = start_r;
  assign cfg.end_addr      = end_r;
  assign cfg.record_length = rlen_r;

endmodule

FILE: hdl/clo_seq.sv
// request sequencer: pipelined byte scan, append write, read-back, erase sweep
// depends on clo_pkg; drives the store ram through a clo_pkg::mem_req_t
module clo_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  clo_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [clo_pkg::DATA_W-1:0]  in_wr_data,
  input  logic [clo_pkg::ADDR_W-1:0]  in_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [clo_pkg::DATA_W-1:0]  out_read_data,
  output clo_pkg::mem_req_t           mem_req,
  input  logic [clo_pkg::DATA_W-1:0]  mem_rdata
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RDTGT = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int AW = clo_pkg::ADDR_W;
  localparam int DW = clo_pkg::DATA_W;
  localparam int TW = clo_pkg::TGT_W;

  logic [2:0]    state_r, state_nxt;
  logic [AW:0]   chk_r, chk_nxt;        // address whose data arrives this cycle
  logic [AW-1:0] ptr_r, ptr_nxt;        // log pointer
  logic          is_read_r, is_read_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic [AW-1:0] offs_r, offs_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    res_stat_r, res_stat_nxt;
  logic [DW-1:0] res_data_r, res_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;

  logic          found;
  logic          clr_last;
  logic [AW:0]   chk_inc;
  logic signed [TW-1:0] target;

  assign found    = (mem_rdata == clo_pkg::ERASED);
  assign clr_last = (clr_r == AW'(clo_pkg::STORE_DEPTH - 1));
  assign chk_inc  = chk_r + (AW+1)'(1);
  assign target   = $signed(TW'(chk_r)) - $signed(TW'(cfg.record_length))
                  + $signed(TW'(offs_r));

  always_comb begin
    state_nxt     = state_r;
    chk_nxt       = chk_r;
    ptr_nxt       = ptr_r;
    is_read_nxt   = is_read_r;
    data_nxt      = data_r;
    offs_nxt      = offs_r;
    clr_nxt       = clr_r;
    res_stat_nxt  = res_stat_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_data_nxt  = out_data_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = clr_r;
    mem_req.wdata = clo_pkg::ERASED;
    mem_req.raddr = chk_inc[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        mem_req.we = 1'b1;
        clr_nxt    = clr_r + AW'(1);
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_wr_data;
          offs_nxt = in_offset;
          case (in_func)
            clo_pkg::FUNC_APPEND: begin
              mem_req.raddr = ptr_r;
              chk_nxt       = {1'b0, ptr_r};
              is_read_nxt   = 1'b0;
              state_nxt     = ST_SCAN;
            end
            clo_pkg::FUNC_READ: begin
              mem_req.raddr = cfg.start_addr;
              chk_nxt       = {1'b0, cfg.start_addr};
              is_read_nxt   = 1'b1;
              state_nxt     = ST_SCAN;
            end
            clo_pkg::FUNC_ERASE: begin
              clr_nxt      = '0;
              res_stat_nxt = clo_pkg::STAT_OK;
              res_data_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              res_stat_nxt = clo_pkg::STAT_NODATA;
              res_data_nxt = '0;
              state_nxt    = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          if (!is_read_r) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = chk_r[AW-1:0];
            mem_req.wdata = data_r;
            ptr_nxt       = chk_r[AW-1:0];
            res_stat_nxt  = clo_pkg::STAT_OK;
            res_data_nxt  = '0;
            state_nxt     = ST_DONE;
          end else if (target < $signed(TW'(cfg.start_addr))) begin
            ptr_nxt      = cfg.start_addr;
            res_stat_nxt = clo_pkg::STAT_NODATA;
            res_data_nxt = clo_pkg::ERASED;
            state_nxt    = ST_DONE;
          end else begin
            ptr_nxt       = target[AW-1:0];
            mem_req.raddr = target[AW-1:0];
            state_nxt     = ST_RDTGT;
          end
        end else if (chk_inc > {1'b0, cfg.end_addr}) begin
          if (!is_read_r) begin
            // log full: wipe the store and restart at the region start
            ptr_nxt      = cfg.start_addr;
            res_stat_nxt = clo_pkg::STAT_CLEARED;
            res_data_nxt = '0;
            clr_nxt      = '0;
            state_nxt    = ST_CLEAR;
          end else begin
            res_stat_nxt = clo_pkg::STAT_NODATA;
            res_data_nxt = clo_pkg::ERASED;
            state_nxt    = ST_DONE;
          end
        end else begin
          chk_nxt = chk_inc;
        end
      end
      ST_RDTGT: begin
        res_stat_nxt = clo_pkg::STAT_OK;
        res_data_nxt = mem_rdata;
        state_nxt    = ST_DONE;
      end
      ST_CLEAR: begin
        mem_req.we = 1'b1;
        clr_nxt    = clr_r + AW'(1);
        if (clr_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_data_nxt  = res_data_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    is_read_r  <= is_read_nxt;
    data_r     <= data_nxt;
    offs_r     <= offs_nxt;
    res_stat_r <= res_stat_nxt;
    res_data_r <= res_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_stat_r;
  assign out_read_data = out_data_r;

endmodule
